FILE: sv/bfu_pkg.sv
`timescale 1ns / 1ps
package bfu_pkg;

    localparam int MAX_BOIDS    = 64;
    localparam int IDX_W        = $clog2(MAX_BOIDS);
    localparam int WORLD_WIDTH  = 800;
    localparam int WORLD_HEIGHT = 600;
    localparam int BOID_SPEED   = 3;

    // wrap moduli in Q.14
    localparam logic signed [25:0] WRAP_X = 26'(WORLD_WIDTH * 16384);
    localparam logic signed [25:0] WRAP_Y = 26'(WORLD_HEIGHT * 16384);

    // configuration register indexes
    localparam logic [2:0] CFG_COUNT     = 3'd0;
    localparam logic [2:0] CFG_COH_RAD   = 3'd1;
    localparam logic [2:0] CFG_SEP_RAD   = 3'd2;
    localparam logic [2:0] CFG_CLOSE_RAD = 3'd3;
    localparam logic [2:0] CFG_ALI_RAD   = 3'd4;
    localparam logic [2:0] CFG_COH_GAIN  = 3'd5;
    localparam logic [2:0] CFG_SEP_GAIN  = 3'd6;
    localparam logic [2:0] CFG_ALI_GAIN  = 3'd7;

    localparam logic [6:0]  RST_COUNT     = 7'd64;
    localparam logic [9:0]  RST_COH_RAD   = 10'd100;
    localparam logic [9:0]  RST_SEP_RAD   = 10'd20;
    localparam logic [9:0]  RST_CLOSE_RAD = 10'd10;
    localparam logic [9:0]  RST_ALI_RAD   = 10'd30;
    localparam logic [11:0] RST_COH_GAIN  = 12'd82;
    localparam logic [11:0] RST_SEP_GAIN  = 12'd246;
    localparam logic [11:0] RST_ALI_GAIN  = 12'd410;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // steering rules; RULE_NORM reuses the divider for normalization
    localparam logic [1:0] RULE_COH  = 2'd0;
    localparam logic [1:0] RULE_SEP  = 2'd1;
    localparam logic [1:0] RULE_ALI  = 2'd2;
    localparam logic [1:0] RULE_NORM = 2'd3;

    // datapath operations
    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LOAD     = 5'd1;
    localparam logic [4:0] OP_RD_SELF  = 5'd2;
    localparam logic [4:0] OP_GET_SELF = 5'd3;
    localparam logic [4:0] OP_SCAN     = 5'd4;
    localparam logic [4:0] OP_NP       = 5'd5;
    localparam logic [4:0] OP_DIFF     = 5'd6;
    localparam logic [4:0] OP_MUL      = 5'd7;
    localparam logic [4:0] OP_DIV_GO   = 5'd8;
    localparam logic [4:0] OP_ADD      = 5'd9;
    localparam logic [4:0] OP_SHIFT    = 5'd10;
    localparam logic [4:0] OP_SQ       = 5'd11;
    localparam logic [4:0] OP_SUMSQ    = 5'd12;
    localparam logic [4:0] OP_SQRT_GO  = 5'd13;
    localparam logic [4:0] OP_CEILSQ   = 5'd14;
    localparam logic [4:0] OP_CEIL     = 5'd15;
    localparam logic [4:0] OP_MOVE1    = 5'd16;
    localparam logic [4:0] OP_MOVE2    = 5'd17;
    localparam logic [4:0] OP_WRITE    = 5'd18;

    localparam int DIV_NW = 42;
    localparam int DIV_DW = 28;
    localparam int SQ_W   = 56;

    typedef struct packed {
        logic                  action;
        logic [5:0]            boid_index;
        logic [15:0]           load_pos_x;
        logic [15:0]           load_pos_y;
        logic signed [15:0]    load_dir_x;
        logic signed [15:0]    load_dir_y;
    } t_in;

    typedef struct packed {
        logic [5:0]            out_index;
        logic [15:0]           out_pos_x;
        logic [15:0]           out_pos_y;
        logic signed [15:0]    out_dir_x;
        logic signed [15:0]    out_dir_y;
    } t_out;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] rule;
        logic       comp;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic n_zero;
        logic div_done;
        logic sqrt_done;
        logic dir_zero;
        logic norm_ok;
    } t_stat;

endpackage

FILE: sv/bfu_div.sv
`timescale 1ns / 1ps
module bfu_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [bfu_pkg::DIV_NW-1:0]    i_dividend,
    input  logic [bfu_pkg::DIV_DW-1:0]    i_divisor,
    output logic                          o_done,
    output logic [bfu_pkg::DIV_NW-1:0]    o_quot
);
    logic [bfu_pkg::DIV_DW:0]     r_rem;
    logic [bfu_pkg::DIV_NW-1:0]   r_quo;
    logic [bfu_pkg::DIV_DW-1:0]   r_div;
    logic [5:0]                   r_cnt;
    logic                         r_run;
    logic                         r_done;
    logic [bfu_pkg::DIV_DW:0]     w_trial;
    logic                         w_ge;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem[bfu_pkg::DIV_DW-1:0], r_quo[bfu_pkg::DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 6'(bfu_pkg::DIV_NW - 1);
        end else if (r_run) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_div}) : w_trial;
            r_quo <= {r_quo[bfu_pkg::DIV_NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

FILE: sv/bfu_sqrt.sv
`timescale 1ns / 1ps
module bfu_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic [bfu_pkg::SQ_W-1:0]      i_value,
    output logic                          o_done,
    output logic [bfu_pkg::SQ_W/2-1:0]    o_root
);
    logic [bfu_pkg::SQ_W-1:0] r_x;
    logic [bfu_pkg::SQ_W-1:0] r_r;
    logic [bfu_pkg::SQ_W-1:0] r_bit;
    logic [4:0]               r_cnt;
    logic                     r_run;
    logic                     r_done;
    logic [bfu_pkg::SQ_W-1:0] w_try;

    assign w_try = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 5'(bfu_pkg::SQ_W / 2 - 1);
        end else if (r_run) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_x   <= i_value;
            r_r   <= '0;
            r_bit <= {2'b01, {(bfu_pkg::SQ_W - 2){1'b0}}};
        end else if (r_run) begin
            if (r_x >= w_try) begin
                r_x <= r_x - w_try;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[bfu_pkg::SQ_W/2-1:0];
endmodule

FILE: sv/bfu_datapath.sv
`timescale 1ns / 1ps
module bfu_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bfu_pkg::t_cmd        i_cmd,
    output bfu_pkg::t_stat       o_stat,
    input  bfu_pkg::t_in         i_in,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data,
    output logic                 o_valid,
    output bfu_pkg::t_out        o_out
);
    // configuration
    logic [6:0]  r_cfg_count;
    logic [9:0]  r_rad_c, r_rad_s, r_rad_k, r_rad_a;
    logic [11:0] r_gain_c, r_gain_s, r_gain_a;
    logic [31:0] r_lim_c, r_lim_s, r_lim_k, r_lim_a;
    logic [6:0]  w_cnt;

    // boid table: {x, y, heading x, heading y}
    logic [63:0] mem [0:bfu_pkg::MAX_BOIDS-1];
    logic [63:0] r_rd_data;
    logic [5:0]  w_rd_addr;

    // own entry and working heading
    logic [5:0]          r_idx;
    logic [15:0]         r_px, r_py;
    logic signed [27:0]  r_dx, r_dy;
    logic signed [16:0]  r_nx, r_ny;

    // scan pipeline
    logic [6:0]          r_scan_i;
    logic                r_s1_v;
    logic [5:0]          r_s1_idx;
    logic                r_s2_v;
    logic [31:0]         r_ex2, r_ey2;
    logic [63:0]         r_s2_ent;
    logic                r_s3_v;
    logic                r_s3_c, r_s3_s, r_s3_k, r_s3_a;
    logic [63:0]         r_s3_ent;
    logic signed [16:0]  w_ex, w_ey;
    logic [32:0]         w_d2;

    // sums
    logic [23:0]         r_csx, r_csy, r_ssx, r_ssy;
    logic signed [22:0]  r_asx, r_asy;
    logic [6:0]          r_cn, r_sn, r_an;

    // steering arithmetic
    logic [22:0]         r_np;
    logic signed [24:0]  r_diff;
    logic signed [37:0]  r_prod;
    logic [37:0]         w_prod_abs;
    logic                r_neg;
    logic [6:0]          w_n;
    logic [15:0]         w_p;
    logic [23:0]         w_s;
    logic signed [22:0]  w_h;
    logic [11:0]         w_gain;
    logic signed [27:0]  w_dcomp;
    logic [27:0]         w_dabs;
    logic [27:0]         w_adx, w_ady;
    logic signed [27:0]  w_term;

    logic [bfu_pkg::DIV_NW-1:0]  w_dividend;
    logic [bfu_pkg::DIV_DW-1:0]  w_divisor;
    logic [bfu_pkg::DIV_NW-1:0]  w_quot;
    logic                        w_div_done;

    // normalization
    logic [55:0]         r_sqx, r_sqy, r_ssum, r_rr;
    logic [27:0]         w_root;
    logic [27:0]         r_len;
    logic                w_sqrt_done;

    // move
    logic signed [25:0]  r_vx, r_vy;
    logic signed [25:0]  r_wx, r_wy;

    logic                r_valid;
    bfu_pkg::t_out       r_out;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= bfu_pkg::RST_COUNT;
            r_rad_c     <= bfu_pkg::RST_COH_RAD;
            r_rad_s     <= bfu_pkg::RST_SEP_RAD;
            r_rad_k     <= bfu_pkg::RST_CLOSE_RAD;
            r_rad_a     <= bfu_pkg::RST_ALI_RAD;
            r_gain_c    <= bfu_pkg::RST_COH_GAIN;
            r_gain_s    <= bfu_pkg::RST_SEP_GAIN;
            r_gain_a    <= bfu_pkg::RST_ALI_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfu_pkg::CFG_COUNT:     r_cfg_count <= i_cfg_data[6:0];
                bfu_pkg::CFG_COH_RAD:   r_rad_c     <= i_cfg_data[9:0];
                bfu_pkg::CFG_SEP_RAD:   r_rad_s     <= i_cfg_data[9:0];
                bfu_pkg::CFG_CLOSE_RAD: r_rad_k     <= i_cfg_data[9:0];
                bfu_pkg::CFG_ALI_RAD:   r_rad_a     <= i_cfg_data[9:0];
                bfu_pkg::CFG_COH_GAIN:  r_gain_c    <= i_cfg_data;
                bfu_pkg::CFG_SEP_GAIN:  r_gain_s    <= i_cfg_data;
                bfu_pkg::CFG_ALI_GAIN:  r_gain_a    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // squared radius limits in Q.6 units
    always_ff @(posedge i_clk) begin
        r_lim_c <= 32'({r_rad_c, 6'd0}) * 32'({r_rad_c, 6'd0});
        r_lim_s <= 32'({r_rad_s, 6'd0}) * 32'({r_rad_s, 6'd0});
        r_lim_k <= 32'({r_rad_k, 6'd0}) * 32'({r_rad_k, 6'd0});
        r_lim_a <= 32'({r_rad_a, 6'd0}) * 32'({r_rad_a, 6'd0});
    end

    assign w_cnt = (r_cfg_count > 7'(bfu_pkg::MAX_BOIDS)) ?
                   7'(bfu_pkg::MAX_BOIDS) : r_cfg_count;

    // ---------------- table ----------------
    assign w_rd_addr = (i_cmd.op == bfu_pkg::OP_RD_SELF) ? i_in.boid_index : r_scan_i[5:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bfu_pkg::OP_LOAD) begin
            mem[i_in.boid_index] <= {i_in.load_pos_x, i_in.load_pos_y,
                                     i_in.load_dir_x, i_in.load_dir_y};
        end else if (i_cmd.op == bfu_pkg::OP_WRITE) begin
            mem[r_idx] <= {r_wx[23:8], r_wy[23:8], r_nx[15:0], r_ny[15:0]};
        end
        r_rd_data <= mem[w_rd_addr];
    end

    // ---------------- scan ----------------
    assign w_ex = $signed({1'b0, r_rd_data[63:48]}) - $signed({1'b0, r_px});
    assign w_ey = $signed({1'b0, r_rd_data[47:32]}) - $signed({1'b0, r_py});
    assign w_d2 = {1'b0, r_ex2} + {1'b0, r_ey2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v   <= 1'b0;
            r_s2_v   <= 1'b0;
            r_s3_v   <= 1'b0;
            r_scan_i <= '0;
        end else begin
            r_s1_v <= 1'b0;
            if (i_cmd.op == bfu_pkg::OP_GET_SELF) begin
                r_scan_i <= '0;
            end else if (i_cmd.op == bfu_pkg::OP_SCAN && r_scan_i < w_cnt) begin
                r_scan_i <= r_scan_i + 7'd1;
                r_s1_v   <= 1'b1;
            end
            // drop the boid's own entry
            r_s2_v <= r_s1_v && (r_s1_idx != r_idx);
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_scan_i[5:0];
        r_ex2    <= 32'(34'(w_ex) * 34'(w_ex));
        r_ey2    <= 32'(34'(w_ey) * 34'(w_ey));
        r_s2_ent <= r_rd_data;
        r_s3_c   <= w_d2 < {1'b0, r_lim_c};
        r_s3_s   <= w_d2 < {1'b0, r_lim_s};
        r_s3_k   <= w_d2 < {1'b0, r_lim_k};
        r_s3_a   <= w_d2 < {1'b0, r_lim_a};
        r_s3_ent <= r_s2_ent;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bfu_pkg::OP_GET_SELF) begin
            r_csx <= '0; r_csy <= '0; r_cn <= '0;
            r_ssx <= '0; r_ssy <= '0; r_sn <= '0;
            r_asx <= '0; r_asy <= '0; r_an <= '0;
        end else if (r_s3_v) begin
            if (r_s3_c) begin
                r_csx <= r_csx + 24'(r_s3_ent[63:48]);
                r_csy <= r_csy + 24'(r_s3_ent[47:32]);
                r_cn  <= r_cn + 7'd1;
            end
            if (r_s3_s) begin
                if (r_s3_k) begin
                    r_ssx <= r_ssx + 24'({r_s3_ent[63:48], 1'b0});
                    r_ssy <= r_ssy + 24'({r_s3_ent[47:32], 1'b0});
                end else begin
                    r_ssx <= r_ssx + 24'(r_s3_ent[63:48]);
                    r_ssy <= r_ssy + 24'(r_s3_ent[47:32]);
                end
                r_sn <= r_sn + 7'd1;
            end
            if (r_s3_a) begin
                r_asx <= r_asx + 23'($signed(r_s3_ent[31:16]));
                r_asy <= r_asy + 23'($signed(r_s3_ent[15:0]));
                r_an  <= r_an + 7'd1;
            end
        end
    end

    // ---------------- steering ----------------
    always_comb begin
        case (i_cmd.rule)
            bfu_pkg::RULE_COH: begin
                w_n    = r_cn;
                w_s    = i_cmd.comp ? r_csy : r_csx;
                w_gain = r_gain_c;
            end
            bfu_pkg::RULE_SEP: begin
                w_n    = r_sn;
                w_s    = i_cmd.comp ? r_ssy : r_ssx;
                w_gain = r_gain_s;
            end
            default: begin
                w_n    = r_an;
                w_s    = '0;
                w_gain = r_gain_a;
            end
        endcase
    end

    assign w_p        = i_cmd.comp ? r_py : r_px;
    assign w_h        = i_cmd.comp ? r_asy : r_asx;
    assign w_dcomp    = i_cmd.comp ? r_dy : r_dx;
    assign w_dabs     = w_dcomp[27] ? 28'(-w_dcomp) : 28'(w_dcomp);
    assign w_prod_abs = r_prod[37] ? 38'(-r_prod) : 38'(r_prod);
    assign w_adx      = r_dx[27] ? 28'(-r_dx) : 28'(r_dx);
    assign w_ady      = r_dy[27] ? 28'(-r_dy) : 28'(r_dy);

    always_comb begin
        case (i_cmd.rule)
            bfu_pkg::RULE_NORM: begin
                w_dividend = {w_dabs, 14'd0};
                w_divisor  = r_len;
            end
            bfu_pkg::RULE_ALI: begin
                w_dividend = 42'(w_prod_abs >> 12);
                w_divisor  = 28'(w_n);
            end
            default: begin
                w_dividend = 42'(w_prod_abs >> 4);
                w_divisor  = 28'(w_n);
            end
        endcase
    end

    assign w_term = r_neg ? -$signed(w_quot[27:0]) : $signed(w_quot[27:0]);

    bfu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.op == bfu_pkg::OP_DIV_GO),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    bfu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.op == bfu_pkg::OP_SQRT_GO),
        .i_value (r_ssum),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            bfu_pkg::OP_RD_SELF: begin
                r_idx <= i_in.boid_index;
            end
            bfu_pkg::OP_GET_SELF: begin
                r_px <= r_rd_data[63:48];
                r_py <= r_rd_data[47:32];
                r_dx <= 28'($signed(r_rd_data[31:16]));
                r_dy <= 28'($signed(r_rd_data[15:0]));
                r_nx <= '0;
                r_ny <= '0;
            end
            bfu_pkg::OP_NP: begin
                r_np <= 23'(w_n) * 23'(w_p);
            end
            bfu_pkg::OP_DIFF: begin
                if (i_cmd.rule == bfu_pkg::RULE_ALI) begin
                    r_diff <= 25'(w_h);
                end else begin
                    r_diff <= $signed({1'b0, w_s}) - $signed({2'b0, r_np});
                end
            end
            bfu_pkg::OP_MUL: begin
                r_prod <= 38'(r_diff) * 38'($signed({1'b0, w_gain}));
            end
            bfu_pkg::OP_DIV_GO: begin
                r_neg <= (i_cmd.rule == bfu_pkg::RULE_NORM) ? w_dcomp[27] : r_prod[37];
            end
            bfu_pkg::OP_ADD: begin
                case (i_cmd.rule)
                    bfu_pkg::RULE_NORM: begin
                        if (i_cmd.comp) r_ny <= w_term[16:0];
                        else            r_nx <= w_term[16:0];
                    end
                    bfu_pkg::RULE_SEP: begin
                        if (i_cmd.comp) r_dy <= r_dy - w_term;
                        else            r_dx <= r_dx - w_term;
                    end
                    default: begin
                        if (i_cmd.comp) r_dy <= r_dy + w_term;
                        else            r_dx <= r_dx + w_term;
                    end
                endcase
            end
            bfu_pkg::OP_SHIFT: begin
                if (!o_stat.norm_ok) begin
                    r_dx <= r_dx <<< 1;
                    r_dy <= r_dy <<< 1;
                end
            end
            bfu_pkg::OP_SQ: begin
                r_sqx <= 56'(w_adx) * 56'(w_adx);
                r_sqy <= 56'(w_ady) * 56'(w_ady);
            end
            bfu_pkg::OP_SUMSQ: begin
                r_ssum <= r_sqx + r_sqy;
            end
            bfu_pkg::OP_CEILSQ: begin
                r_rr <= 56'(w_root) * 56'(w_root);
            end
            bfu_pkg::OP_CEIL: begin
                r_len <= w_root + 28'(r_rr < r_ssum);
            end
            bfu_pkg::OP_MOVE1: begin
                r_vx <= $signed({2'b0, r_px, 8'd0}) + 26'(r_nx) * 26'(bfu_pkg::BOID_SPEED);
                r_vy <= $signed({2'b0, r_py, 8'd0}) + 26'(r_ny) * 26'(bfu_pkg::BOID_SPEED);
            end
            bfu_pkg::OP_MOVE2: begin
                // value stays within one world span on either side
                if (r_vx < 0)                     r_wx <= r_vx + bfu_pkg::WRAP_X;
                else if (r_vx >= bfu_pkg::WRAP_X) r_wx <= r_vx - bfu_pkg::WRAP_X;
                else                              r_wx <= r_vx;
                if (r_vy < 0)                     r_wy <= r_vy + bfu_pkg::WRAP_Y;
                else if (r_vy >= bfu_pkg::WRAP_Y) r_wy <= r_vy - bfu_pkg::WRAP_Y;
                else                              r_wy <= r_vy;
            end
            bfu_pkg::OP_WRITE: begin
                r_out.out_index <= r_idx;
                r_out.out_pos_x <= r_wx[23:8];
                r_out.out_pos_y <= r_wy[23:8];
                r_out.out_dir_x <= r_nx[15:0];
                r_out.out_dir_y <= r_ny[15:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == bfu_pkg::OP_WRITE);
        end
    end

    assign o_stat.scan_done = (r_scan_i == w_cnt) && !r_s1_v && !r_s2_v && !r_s3_v;
    assign o_stat.n_zero    = (w_n == 7'd0);
    assign o_stat.div_done  = w_div_done;
    assign o_stat.sqrt_done = w_sqrt_done;
    assign o_stat.dir_zero  = (r_dx == 28'sd0) && (r_dy == 28'sd0);
    assign o_stat.norm_ok   = (w_adx[27:26] != 2'b00) || (w_ady[27:26] != 2'b00);

    assign o_valid = r_valid;
    assign o_out   = r_out;
endmodule

FILE: sv/bfu_ctrl.sv
`timescale 1ns / 1ps
module bfu_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_action,
    input  bfu_pkg::t_stat   i_stat,
    output bfu_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SELF   = 5'd1;
    localparam logic [4:0] S_SCAN   = 5'd2;
    localparam logic [4:0] S_CHK    = 5'd3;
    localparam logic [4:0] S_NP     = 5'd4;
    localparam logic [4:0] S_DIFF   = 5'd5;
    localparam logic [4:0] S_MUL    = 5'd6;
    localparam logic [4:0] S_DIV    = 5'd7;
    localparam logic [4:0] S_DWAIT  = 5'd8;
    localparam logic [4:0] S_ADD    = 5'd9;
    localparam logic [4:0] S_ZCHK   = 5'd10;
    localparam logic [4:0] S_SHIFT  = 5'd11;
    localparam logic [4:0] S_SQ     = 5'd12;
    localparam logic [4:0] S_SUMSQ  = 5'd13;
    localparam logic [4:0] S_SQRT   = 5'd14;
    localparam logic [4:0] S_SQWAIT = 5'd15;
    localparam logic [4:0] S_CEILSQ = 5'd16;
    localparam logic [4:0] S_CEIL   = 5'd17;
    localparam logic [4:0] S_MOVE1  = 5'd18;
    localparam logic [4:0] S_MOVE2  = 5'd19;
    localparam logic [4:0] S_WRITE  = 5'd20;

    logic [4:0] r_state, n_state;
    logic [1:0] r_rule, n_rule;
    logic       r_comp, n_comp;
    logic [4:0] w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rule  <= bfu_pkg::RULE_COH;
            r_comp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rule  <= n_rule;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rule  = r_rule;
        n_comp  = r_comp;
        w_op    = bfu_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == bfu_pkg::ACT_LOAD) begin
                        w_op = bfu_pkg::OP_LOAD;
                    end else begin
                        w_op    = bfu_pkg::OP_RD_SELF;
                        n_state = S_SELF;
                    end
                end
            end
            S_SELF: begin
                w_op    = bfu_pkg::OP_GET_SELF;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                w_op = bfu_pkg::OP_SCAN;
                if (i_stat.scan_done) begin
                    n_state = S_CHK;
                    n_rule  = bfu_pkg::RULE_COH;
                    n_comp  = 1'b0;
                end
            end
            S_CHK: begin
                // skip a rule without neighbors
                if (!i_stat.n_zero)                  n_state = S_NP;
                else if (r_rule == bfu_pkg::RULE_ALI) n_state = S_ZCHK;
                else                                  n_rule  = r_rule + 2'd1;
            end
            S_NP: begin
                w_op    = bfu_pkg::OP_NP;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                w_op    = bfu_pkg::OP_DIFF;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_op    = bfu_pkg::OP_MUL;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_op    = bfu_pkg::OP_DIV_GO;
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) n_state = S_ADD;
            end
            S_ADD: begin
                w_op = bfu_pkg::OP_ADD;
                if (!r_comp) begin
                    n_comp  = 1'b1;
                    n_state = (r_rule == bfu_pkg::RULE_NORM) ? S_DIV : S_NP;
                end else begin
                    n_comp = 1'b0;
                    if (r_rule == bfu_pkg::RULE_NORM) begin
                        n_state = S_MOVE1;
                    end else if (r_rule == bfu_pkg::RULE_ALI) begin
                        n_state = S_ZCHK;
                    end else begin
                        n_rule  = r_rule + 2'd1;
                        n_state = S_CHK;
                    end
                end
            end
            S_ZCHK: begin
                n_state = i_stat.dir_zero ? S_MOVE1 : S_SHIFT;
            end
            S_SHIFT: begin
                w_op = bfu_pkg::OP_SHIFT;
                if (i_stat.norm_ok) n_state = S_SQ;
            end
            S_SQ: begin
                w_op    = bfu_pkg::OP_SQ;
                n_state = S_SUMSQ;
            end
            S_SUMSQ: begin
                w_op    = bfu_pkg::OP_SUMSQ;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                w_op    = bfu_pkg::OP_SQRT_GO;
                n_state = S_SQWAIT;
            end
            S_SQWAIT: begin
                if (i_stat.sqrt_done) n_state = S_CEILSQ;
            end
            S_CEILSQ: begin
                w_op    = bfu_pkg::OP_CEILSQ;
                n_state = S_CEIL;
            end
            S_CEIL: begin
                w_op    = bfu_pkg::OP_CEIL;
                n_state = S_DIV;
                n_rule  = bfu_pkg::RULE_NORM;
                n_comp  = 1'b0;
            end
            S_MOVE1: begin
                w_op    = bfu_pkg::OP_MOVE1;
                n_state = S_MOVE2;
            end
            S_MOVE2: begin
                w_op    = bfu_pkg::OP_MOVE2;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                w_op    = bfu_pkg::OP_WRITE;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd.op   = w_op;
    assign o_cmd.rule = r_rule;
    assign o_cmd.comp = r_comp;
    assign o_busy     = (r_state != S_IDLE);
endmodule

FILE: sv/boids_flocking_update.sv
`timescale 1ns / 1ps
// Boid table with one-at-a-time flocking update.
// Command channel: drive i_in and raise start; the transfer happens at an edge
// where start is high and busy is low. A load (action 0) writes one table entry
// at that edge and leaves busy low, so loads can follow every cycle.
// An update (action 1) holds busy high up to the cycle before its result shows;
// a new command may transfer in the result cycle.
// Result channel: o_valid is high for exactly one cycle with o_out; the
// receiver cannot stall it and must take it in that cycle.
// An update's duration grows with boid_count and with each rule that has
// neighbors (two steering quotients); a nonzero heading adds doubling steps,
// a square root, a ceiling and two normalizing quotients. Each quotient comes
// from the 42-step bit-serial divider.
// Configuration writes land at once through i_cfg_we / i_cfg_idx / i_cfg_data
// and are meant for idle periods only.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle, clears the
// result strobe and restores the register defaults; the table is not cleared.
module boids_flocking_update (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  bfu_pkg::t_in    i_in,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [11:0]     i_cfg_data,
    output logic            o_valid,
    output bfu_pkg::t_out   o_out
);
    bfu_pkg::t_cmd  w_cmd;
    bfu_pkg::t_stat w_stat;

    bfu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_in.action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    bfu_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_out      (o_out)
    );
endmodule

FILE: sv/bfu_checker.sv
`timescale 1ns / 1ps
module bfu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input bfu_pkg::t_in   i_in,
    input logic           o_valid
);
    // a result only ends an update
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy)) else $error("result without update in progress");

    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.action == bfu_pkg::ACT_LOAD) |=> !busy)
        else $error("load transfer made block busy");

    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_in.action == bfu_pkg::ACT_UPDATE) |=> (busy && !o_valid))
        else $error("update transfer did not start work");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid)) else $error("not idle after reset");
endmodule

bind boids_flocking_update bfu_checker u_bfu_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
module tb;
    localparam int ITEM_TARGET = 1900;
    localparam int CYCLE_LIMIT = 5000000;

    class flock_scoreboard;
        logic [15:0]        pos_x_tab[bfu_pkg::MAX_BOIDS];
        logic [15:0]        pos_y_tab[bfu_pkg::MAX_BOIDS];
        logic signed [15:0] head_x_tab[bfu_pkg::MAX_BOIDS];
        logic signed [15:0] head_y_tab[bfu_pkg::MAX_BOIDS];
        int unsigned        regs[8];
        bfu_pkg::t_out      pending_moves[$];
        int                 errors;

        function new();
            for (int i = 0; i < bfu_pkg::MAX_BOIDS; i++) begin
                pos_x_tab[i] = '0;
                pos_y_tab[i] = '0;
                head_x_tab[i] = '0;
                head_y_tab[i] = '0;
            end
            regs[bfu_pkg::CFG_COUNT]     = bfu_pkg::RST_COUNT;
            regs[bfu_pkg::CFG_COH_RAD]   = bfu_pkg::RST_COH_RAD;
            regs[bfu_pkg::CFG_SEP_RAD]   = bfu_pkg::RST_SEP_RAD;
            regs[bfu_pkg::CFG_CLOSE_RAD] = bfu_pkg::RST_CLOSE_RAD;
            regs[bfu_pkg::CFG_ALI_RAD]   = bfu_pkg::RST_ALI_RAD;
            regs[bfu_pkg::CFG_COH_GAIN]  = bfu_pkg::RST_COH_GAIN;
            regs[bfu_pkg::CFG_SEP_GAIN]  = bfu_pkg::RST_SEP_GAIN;
            regs[bfu_pkg::CFG_ALI_GAIN]  = bfu_pkg::RST_ALI_GAIN;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, int unsigned v);
            if (idx == bfu_pkg::CFG_COUNT)
                regs[idx] = v & 32'h7F;
            else if (idx >= bfu_pkg::CFG_COH_GAIN)
                regs[idx] = v & 32'hFFF;
            else
                regs[idx] = v & 32'h3FF;
        endfunction

        function bit near(longint d2, int unsigned r);
            longint lim;
            lim = longint'(r) * 64;
            return d2 < lim * lim;
        endfunction

        function longint unsigned ceil_sqrt(longint unsigned s);
            longint unsigned r, b, x;
            r = 0;
            b = 64'd1 << 62;
            x = s;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (r * r < s) r++;
            return r;
        endfunction

        function void note(bfu_pkg::t_in x);
            int b, cnt;
            longint px, py, dx, dy, ox, oy, ex, ey, d2, w, nx, ny, wx, wy, lim;
            longint csx, csy, cn, ssx, ssy, sn, asx, asy, an;
            longint gc, gs, ga, mx, my;
            longint unsigned len;
            bfu_pkg::t_out e;
            b = x.boid_index;
            if (x.action == bfu_pkg::ACT_LOAD) begin
                pos_x_tab[b] = x.load_pos_x;
                pos_y_tab[b] = x.load_pos_y;
                head_x_tab[b] = x.load_dir_x;
                head_y_tab[b] = x.load_dir_y;
                return;
            end
            px = pos_x_tab[b];
            py = pos_y_tab[b];
            dx = head_x_tab[b];
            dy = head_y_tab[b];
            cnt = regs[bfu_pkg::CFG_COUNT] > bfu_pkg::MAX_BOIDS ?
                  bfu_pkg::MAX_BOIDS : regs[bfu_pkg::CFG_COUNT];
            gc = longint'(regs[bfu_pkg::CFG_COH_GAIN]);
            gs = longint'(regs[bfu_pkg::CFG_SEP_GAIN]);
            ga = longint'(regs[bfu_pkg::CFG_ALI_GAIN]);
            mx = longint'(bfu_pkg::WORLD_WIDTH) << 14;
            my = longint'(bfu_pkg::WORLD_HEIGHT) << 14;
            csx = 0; csy = 0; cn = 0; ssx = 0; ssy = 0; sn = 0;
            asx = 0; asy = 0; an = 0; nx = 0; ny = 0;
            for (int i = 0; i < cnt; i++) begin
                if (i == b) continue;
                ox = pos_x_tab[i];
                oy = pos_y_tab[i];
                ex = ox - px;
                ey = oy - py;
                d2 = ex * ex + ey * ey;
                if (near(d2, regs[bfu_pkg::CFG_COH_RAD])) begin
                    csx += ox; csy += oy; cn++;
                end
                if (near(d2, regs[bfu_pkg::CFG_SEP_RAD])) begin
                    w = near(d2, regs[bfu_pkg::CFG_CLOSE_RAD]) ? 2 : 1;
                    ssx += w * ox; ssy += w * oy; sn++;
                end
                if (near(d2, regs[bfu_pkg::CFG_ALI_RAD])) begin
                    asx += longint'(head_x_tab[i]);
                    asy += longint'(head_y_tab[i]);
                    an++;
                end
            end
            if (cn != 0) begin
                dx += ((csx - cn * px) * gc) / (16 * cn);
                dy += ((csy - cn * py) * gc) / (16 * cn);
            end
            if (sn != 0) begin
                dx -= ((ssx - sn * px) * gs) / (16 * sn);
                dy -= ((ssy - sn * py) * gs) / (16 * sn);
            end
            if (an != 0) begin
                dx += (asx * ga) / (4096 * an);
                dy += (asy * ga) / (4096 * an);
            end
            // zero heading stays zero and the boid's position is only wrapped into the world
            if (dx != 0 || dy != 0) begin
                lim = 64'sd1 << 26;
                while ((dx < 0 ? -dx : dx) < lim && (dy < 0 ? -dy : dy) < lim) begin
                    dx = dx * 2;
                    dy = dy * 2;
                end
                len = ceil_sqrt(longint'(dx * dx) + longint'(dy * dy));
                nx = (dx * 16384) / longint'(len);
                ny = (dy * 16384) / longint'(len);
            end
            wx = (px * 256 + bfu_pkg::BOID_SPEED * nx) % mx;
            if (wx < 0) wx += mx;
            wy = (py * 256 + bfu_pkg::BOID_SPEED * ny) % my;
            if (wy < 0) wy += my;
            pos_x_tab[b] = 16'(wx >> 8);
            pos_y_tab[b] = 16'(wy >> 8);
            head_x_tab[b] = 16'(nx);
            head_y_tab[b] = 16'(ny);
            e.out_index = 6'(b);
            e.out_pos_x = pos_x_tab[b];
            e.out_pos_y = pos_y_tab[b];
            e.out_dir_x = head_x_tab[b];
            e.out_dir_y = head_y_tab[b];
            pending_moves.push_back(e);
        endfunction

        function void check(bfu_pkg::t_out y);
            bfu_pkg::t_out e;
            if (pending_moves.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: idx %0d pos %0d,%0d dir %0d,%0d",
                             y.out_index, y.out_pos_x, y.out_pos_y,
                             y.out_dir_x, y.out_dir_y);
                return;
            end
            e = pending_moves.pop_front();
            if (y.out_index !== e.out_index || y.out_pos_x !== e.out_pos_x ||
                y.out_pos_y !== e.out_pos_y || y.out_dir_x !== e.out_dir_x ||
                y.out_dir_y !== e.out_dir_y) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp idx %0d pos %0d,%0d dir %0d,%0d",
                              " / got idx %0d pos %0d,%0d dir %0d,%0d"},
                             e.out_index, e.out_pos_x, e.out_pos_y,
                             e.out_dir_x, e.out_dir_y,
                             y.out_index, y.out_pos_x, y.out_pos_y,
                             y.out_dir_x, y.out_dir_y);
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    bfu_pkg::t_in  i_in = '0;
    logic          i_cfg_we = 1'b0;
    logic [2:0]    i_cfg_idx = bfu_pkg::CFG_COUNT;
    logic [11:0]   i_cfg_data = '0;
    logic          o_valid;
    bfu_pkg::t_out o_out;

    flock_scoreboard board = new();
    int items_sent = 0;
    int burst_left = 0;
    int cycles = 0;

    boids_flocking_update dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_in(i_in),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_out(o_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check(o_out);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // transfer one item, keeping start high across a burst
    task automatic send(bfu_pkg::t_in x);
        int g;
        start <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (busy);
        board.note(x);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 7);
            if (g > 0) begin
                start <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (board.pending_moves.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, int unsigned v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 12'(v);
        @(posedge i_clk);
        board.write_reg(idx, v);
        i_cfg_we <= 1'b0;
    endtask

    function automatic bfu_pkg::t_in make_item(bit act, int idx, int x, int y,
                                               int hx, int hy);
        bfu_pkg::t_in r;
        r.action = act;
        r.boid_index = 6'(idx);
        r.load_pos_x = 16'(x);
        r.load_pos_y = 16'(y);
        r.load_dir_x = 16'(hx);
        r.load_dir_y = 16'(hy);
        return r;
    endfunction

    function automatic int rand_coord(int center, int top);
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, top);
            default: return center - 3000 + $urandom_range(0, 6000);
        endcase
    endfunction

    function automatic int rand_head();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 65535);
            1: return 0;
            2: return 16384;
            3: return -16384;
            default: return $urandom_range(0, 32768) - 16384;
        endcase
    endfunction

    function automatic int unsigned pick_reg(int unsigned top);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return top;
            default: return (top == 1023) ? $urandom_range(0, 200) : $urandom_range(0, top);
        endcase
    endfunction

    initial begin
        bfu_pkg::t_in x;
        int cnt;
        bit ok;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // small table first: only written entries may be searched
        write_cfg(bfu_pkg::CFG_COUNT, 4);
        send(make_item(bfu_pkg::ACT_LOAD, 0, 25600, 19200, 16384, 0));
        send(make_item(bfu_pkg::ACT_LOAD, 1, 25900, 19200, 0, 16384));
        send(make_item(bfu_pkg::ACT_LOAD, 2, 25600, 20200, -16384, -16384));
        send(make_item(bfu_pkg::ACT_LOAD, 3, 51199, 38399, 0, 0));
        send(make_item(bfu_pkg::ACT_UPDATE, 0, 0, 0, 0, 0));
        send(make_item(bfu_pkg::ACT_UPDATE, 1, 65535, 65535, -1, -1));
        send(make_item(bfu_pkg::ACT_UPDATE, 2, 0, 0, 0, 0));
        send(make_item(bfu_pkg::ACT_UPDATE, 3, 0, 0, 0, 0));
        send(make_item(bfu_pkg::ACT_LOAD, 3, 65535, 65535, -16384, 16384));
        send(make_item(bfu_pkg::ACT_UPDATE, 3, 0, 0, 0, 0));
        send(make_item(bfu_pkg::ACT_LOAD, 63, 0, 0, -16384, -16384));
        send(make_item(bfu_pkg::ACT_UPDATE, 63, 0, 0, 0, 0));
        send(make_item(bfu_pkg::ACT_LOAD, 62, 51199, 0, 16384, -16384));
        send(make_item(bfu_pkg::ACT_UPDATE, 62, 0, 0, 0, 0));
        wait_idle();
        write_cfg(bfu_pkg::CFG_COUNT, 0);
        send(make_item(bfu_pkg::ACT_UPDATE, 0, 0, 0, 0, 0));
        send(make_item(bfu_pkg::ACT_UPDATE, 1, 0, 0, 0, 0));
        wait_idle();
        write_cfg(bfu_pkg::CFG_COUNT, 1);
        send(make_item(bfu_pkg::ACT_UPDATE, 0, 0, 0, 0, 0));
        send(make_item(bfu_pkg::ACT_UPDATE, 2, 0, 0, 0, 0));
        wait_idle();

        // fill the whole table so any update is legal from here on
        for (int i = 0; i < bfu_pkg::MAX_BOIDS; i++)
            send(make_item(bfu_pkg::ACT_LOAD, i, rand_coord(25600, 51199),
                           rand_coord(19200, 38399), rand_head(), rand_head()));

        while (items_sent < ITEM_TARGET) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: cnt = 64;
                1: cnt = 127;
                2: cnt = 1;
                3: cnt = 0;
                default: cnt = $urandom_range(0, 127);
            endcase
            write_cfg(bfu_pkg::CFG_COUNT, cnt);
            write_cfg(bfu_pkg::CFG_COH_RAD, pick_reg(1023));
            write_cfg(bfu_pkg::CFG_SEP_RAD, pick_reg(1023));
            write_cfg(bfu_pkg::CFG_CLOSE_RAD, pick_reg(1023));
            write_cfg(bfu_pkg::CFG_ALI_RAD, pick_reg(1023));
            write_cfg(bfu_pkg::CFG_COH_GAIN, pick_reg(4095));
            write_cfg(bfu_pkg::CFG_SEP_GAIN, pick_reg(4095));
            write_cfg(bfu_pkg::CFG_ALI_GAIN, pick_reg(4095));
            repeat ($urandom_range(40, 120)) begin
                x = make_item($urandom_range(0, 99) < 55 ? bfu_pkg::ACT_UPDATE
                                                         : bfu_pkg::ACT_LOAD,
                              $urandom_range(0, 63), rand_coord(25600, 51199),
                              rand_coord(19200, 38399), rand_head(), rand_head());
                send(x);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        ok = (board.errors == 0) && (board.pending_moves.size() == 0);
        if (ok)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

FILE: files.f
sv/bfu_pkg.sv
sv/bfu_div.sv
sv/bfu_sqrt.sv
sv/bfu_datapath.sv
sv/bfu_ctrl.sv
sv/boids_flocking_update.sv
sv/bfu_checker.sv
test/tb.sv
